### sv/acp_pkg.sv
// ----------------------------------------------------------------------------
// acp_pkg
// shared types, codes and helper functions for the angle command parser
// ----------------------------------------------------------------------------
package acp_pkg;

    // parser state codes
    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_MATCH   = 3'd1;
    localparam logic [2:0] ST_QUERY   = 3'd2;
    localparam logic [2:0] ST_SET     = 3'd3;
    localparam logic [2:0] ST_INVALID = 3'd4;

    // result event codes
    localparam logic [2:0] EV_NONE    = 3'd0;
    localparam logic [2:0] EV_QUERY   = 3'd1;
    localparam logic [2:0] EV_SET     = 3'd2;
    localparam logic [2:0] EV_RANGE   = 3'd3;
    localparam logic [2:0] EV_INVALID = 3'd4;

    localparam logic [1:0] KEY_LEN         = 2'd3;
    localparam logic [7:0] MAX_ANGLE_RESET = 8'd180;

    // ascii characters
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_QMARK  = 8'h3f;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_LOW_A  = 8'h61;
    localparam logic [7:0] CH_LOW_Z  = 8'h7a;
    localparam logic [7:0] CASE_DIFF = 8'h20;

    typedef struct packed {
        logic [2:0] event_res;
        logic [7:0] angle;
    } t_result;

    // ascii a..z to upper case, everything else unchanged
    function automatic logic [7:0] fold_upper(input logic [7:0] c);
        if (c >= CH_LOW_A && c <= CH_LOW_Z) begin
            return c - CASE_DIFF;
        end
        return c;
    endfunction

    // keyword letter at a given position, zero past the end
    function automatic logic [7:0] key_char(input logic [1:0] pos);
        case (pos)
            2'd0:    key_char = 8'h41;   // 'A'
            2'd1:    key_char = 8'h4e;   // 'N'
            2'd2:    key_char = 8'h47;   // 'G'
            default: key_char = 8'h00;
        endcase
    endfunction

endpackage

### sv/acp_if.sv
// ----------------------------------------------------------------------------
// acp interfaces
// valid/ready channels for characters, results and configuration
// ----------------------------------------------------------------------------
interface acp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_char;
    logic [7:0] current_angle;

    modport source (output valid, output in_char, output current_angle, input ready);
    modport sink   (input valid, input in_char, input current_angle, output ready);
endinterface

interface acp_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] event_res;
    logic [7:0] angle;

    modport source (output valid, output event_res, output angle, input ready);
    modport sink   (input valid, input event_res, input angle, output ready);
endinterface

interface acp_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] max_angle;

    modport source (output valid, output max_angle, input ready);
    modport sink   (input valid, input max_angle, output ready);
endinterface

### sv/acp_skid.sv
// ----------------------------------------------------------------------------
// acp_skid
// two-entry output buffer: result register plus skid register
// ----------------------------------------------------------------------------
module acp_skid
    import acp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_result i_data,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_data
);

    logic    r_out_valid, n_out_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_out, n_out;
    t_result r_skid, n_skid;
    logic    in_fire, out_fire;

    assign o_ready  = !r_skid_valid;
    assign o_valid  = r_out_valid;
    assign o_data   = r_out;
    assign in_fire  = i_valid && !r_skid_valid;
    assign out_fire = r_out_valid && i_ready;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (out_fire) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end else if (in_fire) begin
                n_out = i_data;
            end else begin
                n_out_valid = 1'b0;
            end
        end else if (in_fire) begin
            if (!r_out_valid) begin
                n_out       = i_data;
                n_out_valid = 1'b1;
            end else begin
                n_skid       = i_data;
                n_skid_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_out  <= n_out;
        r_skid <= n_skid;
    end

endmodule

### sv/angle_command_parser.sv
// ----------------------------------------------------------------------------
// angle_command_parser
// parses "ANG?" query and "ANG <digits>" set lines; while ready is high, one character per cycle
// ----------------------------------------------------------------------------
// each result is registered in the output buffer before it is offered on the output
// throughput: one character per cycle while the output buffer has room (ready drops when the skid is full)
// every character yields exactly one result transaction (event 0 if nothing)
// a two-entry output buffer keeps input accepted while one result is stalled
// reset (synchronous, active low): parser idle, max_angle back to 180
// ----------------------------------------------------------------------------
module angle_command_parser
    import acp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    acp_in_if.sink    i_in,
    acp_cfg_if.sink   i_cfg,
    acp_out_if.source o_out
);

    // parser state
    logic [2:0] r_state, n_state;
    logic [1:0] r_count, n_count;
    logic [7:0] r_accum, n_accum;
    logic [7:0] r_max_angle;

    t_result    res;
    t_result    buf_data;
    logic       buf_ready;
    logic       in_fire;

    // character decode
    logic [7:0] c;
    logic       is_lf, is_cr, is_sp, is_tab, is_digit, key_hit;
    logic [8:0] sat_wide;
    logic [7:0] sat;
    logic [11:0] prod;

    assign c        = i_in.in_char;
    assign is_lf    = (c == CH_LF);
    assign is_cr    = (c == CH_CR);
    assign is_sp    = (c == CH_SPACE);
    assign is_tab   = (c == CH_TAB);
    assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    // next keyword letter matches, only while the keyword is incomplete
    assign key_hit  = (r_count < KEY_LEN) && (fold_upper(c) == key_char(r_count));

    // saturation point: max_angle + 1, held at 255
    assign sat_wide = {1'b0, r_max_angle} + 9'd1;
    assign sat      = sat_wide[8] ? 8'hff : sat_wide[7:0];

    // accum * 10 + digit as shifts and adds
    assign prod = {1'b0, r_accum, 3'b000} + {3'b000, r_accum, 1'b0}
                + {8'h00, c[3:0] - CH_ZERO[3:0]};

    assign in_fire     = i_in.valid && buf_ready;
    assign i_in.ready  = buf_ready;
    // register writes are to happen only while idle (the user's duty, not enforced here); ready is always high
    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_accum       = r_accum;
        res.event_res = EV_NONE;
        res.angle     = 8'h00;
        case (r_state)
            ST_IDLE: begin
                // skip spaces, carriage returns and line feeds before a command
                if (!(is_lf || is_cr || is_sp)) begin
                    if (key_hit) begin
                        n_state = ST_MATCH;
                        n_count = r_count + 2'd1;
                    end else begin
                        n_state = ST_INVALID;
                    end
                end
            end
            ST_MATCH: begin
                if (key_hit) begin
                    n_count = r_count + 2'd1;
                end else if (r_count == KEY_LEN && c == CH_QMARK) begin
                    n_state = ST_QUERY;
                end else if (r_count == KEY_LEN && (is_sp || is_tab)) begin
                    n_state = ST_SET;
                end else if (is_lf) begin
                    res.event_res = EV_INVALID;
                end else begin
                    n_state = ST_INVALID;
                end
            end
            ST_QUERY: begin
                if (!(is_sp || is_cr)) begin
                    if (is_lf) begin
                        res.event_res = EV_QUERY;
                        res.angle     = i_in.current_angle;
                    end else begin
                        n_state = ST_INVALID;
                    end
                end
            end
            ST_SET: begin
                if (!(is_sp || is_cr)) begin
                    if (is_digit) begin
                        // saturate just above the limit
                        if (prod > {4'h0, sat}) begin
                            n_accum = sat;
                        end else begin
                            n_accum = prod[7:0];
                        end
                    end else if (is_lf) begin
                        if (r_accum <= r_max_angle) begin
                            res.event_res = EV_SET;
                            res.angle     = r_accum;
                        end else begin
                            res.event_res = EV_RANGE;
                        end
                    end else begin
                        n_state = ST_INVALID;
                    end
                end
            end
            default: begin
                // invalid line, also covers unused state codes
                if (is_lf) begin
                    res.event_res = EV_INVALID;
                end else begin
                    n_state = ST_INVALID;
                end
            end
        endcase
        // any reported event starts a fresh line
        if (res.event_res != EV_NONE) begin
            n_state = ST_IDLE;
            n_count = 2'd0;
            n_accum = 8'h00;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= 2'd0;
            r_accum     <= 8'h00;
            r_max_angle <= MAX_ANGLE_RESET;
        end else begin
            if (in_fire) begin
                r_state <= n_state;
                r_count <= n_count;
                r_accum <= n_accum;
            end
            if (i_cfg.valid) begin
                r_max_angle <= i_cfg.max_angle;
            end
        end
    end

    // result register and skid stage
    acp_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .o_ready (buf_ready),
        .i_data  (res),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_data  (buf_data)
    );

    assign o_out.event_res = buf_data.event_res;
    assign o_out.angle     = buf_data.angle;

endmodule
